// ===== src/audio_clock_divider_search_top_macros.svh =====
// Assertion macros shared by the checker of the divider search block.
`ifndef AUDIO_CLOCK_DIVIDER_SEARCH_TOP_MACROS_SVH
`define AUDIO_CLOCK_DIVIDER_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ACDS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ACDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/acds_pkg.sv =====
// Package for the audio clock divider search: widths, constants and control structs.
package acds_pkg;

	localparam int unsigned ACDS_MAX_DIVIDER = 255;
	localparam int unsigned DIV_W   = 8;
	localparam int unsigned DEN_W   = DIV_W + 1;
	localparam int unsigned HZ_W    = 32;
	localparam int unsigned FRAME_SHIFT = 8;
	localparam int unsigned QUO_W   = HZ_W - FRAME_SHIFT;
	localparam int unsigned STEP_W  = $clog2(QUO_W);
	localparam int unsigned BOUND_W = HZ_W + 7;
	localparam logic [6:0]  REL_BOUND = 7'd100;
	localparam logic [HZ_W-1:0] CLOCK_RESET = 32'd24576000;
	localparam logic [DIV_W-1:0] DIV_FIRST = 8'd2;
	localparam int unsigned OUT_DATA_W = 80;

	typedef struct packed {
		logic load_item;
		logic div_start;
		logic eval;
		logic load_out;
	} acds_cmd_t;

	typedef struct packed {
		logic div_done;
		logic stop;
		logic out_free;
	} acds_sts_t;

endpackage

// ===== src/acds_sdiv.sv =====
// Restoring serial divider: one quotient bit per cycle.
module acds_sdiv
	import acds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W:0]    diff;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/acds_datapath.sv =====
// Datapath: clock register, candidate counters, divider, best-pair tracking, output register.
module acds_datapath
	import acds_pkg::*;
#(
	parameter int unsigned MAX_DIVIDER = ACDS_MAX_DIVIDER
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  acds_cmd_t             cmd,
	output acds_sts_t             sts,
	input  logic                  cfg_valid,
	input  logic [HZ_W-1:0]       cfg_data,
	input  logic [HZ_W-1:0]       target_hz,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DIV_W-1:0]      divider,
	output logic                  odd_bit,
	output logic [HZ_W-1:0]       real_hz,
	output logic [HZ_W-1:0]       error_hz,
	output logic                  found
);

	logic [HZ_W-1:0]    clk_hz_q;
	logic [HZ_W-1:0]    target_q;
	logic [BOUND_W-1:0] bound_q;
	logic [DIV_W-1:0]   div_q;
	logic               odd_q;
	logic               found_q;
	logic [DIV_W-1:0]   best_div_q;
	logic               best_odd_q;
	logic [HZ_W-1:0]    best_real_q;
	logic [HZ_W-1:0]    best_err_q;
	logic               out_valid_q;
	logic [DIV_W-1:0]   out_div_q;
	logic               out_odd_q;
	logic [HZ_W-1:0]    out_real_q;
	logic [HZ_W-1:0]    out_err_q;
	logic               out_found_q;

	logic               div_done;
	logic [QUO_W-1:0]   quo;
	logic [HZ_W-1:0]    rate;
	logic [HZ_W-1:0]    err;
	logic               better;
	logic               last_cand;

	acds_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (clk_hz_q[HZ_W-1:FRAME_SHIFT]),
		.divisor  ({div_q, odd_q}),
		.done     (div_done),
		.quotient (quo)
	);

	assign rate      = {{FRAME_SHIFT{1'b0}}, quo};
	assign err       = (rate > target_q) ? (rate - target_q) : (target_q - rate);
	assign better    = found_q ? (err < best_err_q)
	                           : ({{(BOUND_W-HZ_W){1'b0}}, err} < bound_q);
	assign last_cand = (div_q == MAX_DIVIDER[DIV_W-1:0]) && odd_q;

	assign sts.div_done = div_done;
	assign sts.stop     = (better && (err == '0)) || last_cand;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q    <= CLOCK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				clk_hz_q <= cfg_data;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			target_q    <= target_hz;
			bound_q     <= BOUND_W'(target_hz) * BOUND_W'(REL_BOUND);
			div_q       <= DIV_FIRST;
			odd_q       <= 1'b0;
			found_q     <= 1'b0;
			best_div_q  <= DIV_FIRST;
			best_odd_q  <= 1'b0;
			best_real_q <= '0;
			best_err_q  <= '0;
		end else if (cmd.eval) begin
			if (better) begin
				found_q     <= 1'b1;
				best_div_q  <= div_q;
				best_odd_q  <= odd_q;
				best_real_q <= rate;
				best_err_q  <= err;
			end
			// advance the sweep: odd bit first, then the divider
			if (odd_q) begin
				odd_q <= 1'b0;
				div_q <= div_q + 1'b1;
			end else begin
				odd_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_div_q   <= best_div_q;
			out_odd_q   <= best_odd_q;
			out_real_q  <= best_real_q;
			out_err_q   <= best_err_q;
			out_found_q <= found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign divider   = out_div_q;
	assign odd_bit   = out_odd_q;
	assign real_hz   = out_real_q;
	assign error_hz  = out_err_q;
	assign found     = out_found_q;

endmodule

// ===== src/acds_ctrl.sv =====
// Controller state machine sequencing the candidate sweep.
module acds_ctrl
	import acds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  acds_sts_t sts,
	output acds_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_START;
				ST_START: state_q <= ST_WAIT;
				ST_WAIT:  if (sts.div_done) state_q <= ST_EVAL;
				ST_EVAL:  state_q <= sts.stop ? ST_DONE : ST_START;
				ST_DONE:  if (sts.out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign cmd.load_item = (state_q == ST_IDLE) && in_valid;
	assign cmd.div_start = (state_q == ST_START);
	assign cmd.eval      = (state_q == ST_EVAL);
	// hold the finished result until the output register frees up
	assign cmd.load_out  = (state_q == ST_DONE) && sts.out_free;

endmodule

// ===== src/audio_clock_divider_search_top.sv =====
// Audio clock divider search: top level with stream ports and clock register write channel.
// Each candidate pair runs in order: start, 24 serial divider steps, done, evaluate.
// Up to 508 candidate pairs (N) are tried per request.
// One request is in flight at a time; the next is taken once the result enters the output register,
// so requests are spaced by the whole sweep, and further while the output side stalls the result.
// arst_n clears control state and sets the clock register to 24576000 Hz.
module audio_clock_divider_search_top
	import acds_pkg::*;
#(
	parameter int unsigned MAX_DIVIDER = ACDS_MAX_DIVIDER
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [HZ_W-1:0]       s_tdata,   // target_hz[31:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // divider[7:0], odd_bit[8], real_hz[40:9],
	                                         // error_hz[72:41], zero pad[79:73]
	output logic                  m_tuser,   // found[0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [HZ_W-1:0]       cfg_data
);

	acds_cmd_t        cmd;
	acds_sts_t        sts;
	logic [DIV_W-1:0] divider;
	logic             odd_bit;
	logic [HZ_W-1:0]  real_hz;
	logic [HZ_W-1:0]  error_hz;

	acds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acds_datapath #(
		.MAX_DIVIDER (MAX_DIVIDER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.target_hz (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.divider   (divider),
		.odd_bit   (odd_bit),
		.real_hz   (real_hz),
		.error_hz  (error_hz),
		.found     (m_tuser)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {{(OUT_DATA_W - DIV_W - 1 - 2*HZ_W){1'b0}},
	                    error_hz, real_hz, odd_bit, divider};

endmodule

// ===== src/acds_checker.sv =====
// Port-level checker for the divider search block, bound to the top level.
`include "audio_clock_divider_search_top_macros.svh"

module acds_checker
	import acds_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// a request starts a multi-cycle sweep, so the input side closes right after
	`ACDS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// no qualifying pair gives the fixed fallback result
	`ACDS_ASSERT_SAME(a_fallback, m_tvalid && !m_tuser,
		(m_tdata[7:0] == 8'd2) && !m_tdata[8] && (m_tdata[72:9] == '0),
		"fallback result mismatch")

	// a found result names a divider at or above the sweep start
	`ACDS_ASSERT_SAME(a_div_range, m_tvalid && m_tuser, m_tdata[7:0] >= 8'd2,
		"divider below sweep start")

	`ACDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
		"stalled result dropped")

endmodule

bind audio_clock_divider_search_top acds_checker u_acds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/tb_audio_clock_divider_search_top.sv =====
// Testbench for the audio clock divider search: directed table, random sweeps, self-checking.
`timescale 1ns / 1ps

module tb_audio_clock_divider_search_top;
	import acds_pkg::*;

	typedef struct packed {
		logic [DIV_W-1:0] divider;
		logic             odd_bit;
		logic [HZ_W-1:0]  real_hz;
		logic [HZ_W-1:0]  error_hz;
		logic             found;
	} search_result_t;

	typedef struct {
		logic [HZ_W-1:0] clock_hz;
		logic [HZ_W-1:0] target;
		bit              typed;
		search_result_t  want;
	} plan_row_t;

	localparam search_result_t NONE_FOUND =
		'{divider: DIV_FIRST, odd_bit: 1'b0, real_hz: '0, error_hz: '0, found: 1'b0};
	localparam int PLAN_ROWS = 18;
	localparam int HOLD_CYCLES = 30000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [HZ_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [HZ_W-1:0]       cfg_data;

	logic [HZ_W-1:0] clock_hz = CLOCK_RESET;
	search_result_t  awaited_results [$];
	int              bad_fields = 0;
	int              results_seen = 0;
	int              send_idle_pct = 16;
	int              recv_idle_pct = 87;

	// Clock, expected result (typed rows only)
	plan_row_t plan [PLAN_ROWS] = '{
		'{CLOCK_RESET, 32'd24000, 1'b1, '{8'd2, 1'b0, 32'd24000, 32'd0, 1'b1}},
		'{CLOCK_RESET, 32'd19200, 1'b1, '{8'd2, 1'b1, 32'd19200, 32'd0, 1'b1}},
		'{CLOCK_RESET, 32'd12000, 1'b1, '{8'd4, 1'b0, 32'd12000, 32'd0, 1'b1}},
		'{CLOCK_RESET, 32'd187, 1'b1, '{8'd255, 1'b1, 32'd187, 32'd0, 1'b1}},
		'{CLOCK_RESET, 32'd48000, 1'b1, '{8'd2, 1'b0, 32'd24000, 32'd24000, 1'b1}},
		'{CLOCK_RESET, 32'd0, 1'b1, NONE_FOUND},
		'{CLOCK_RESET, 32'd1, 1'b1, NONE_FOUND},
		'{CLOCK_RESET, 32'hFFFF_FFFF, 1'b1,
			'{8'd2, 1'b0, 32'd24000, 32'd4294943295, 1'b1}},
		'{CLOCK_RESET, 32'd2, 1'b0, NONE_FOUND},
		'{CLOCK_RESET, 32'd44100, 1'b0, NONE_FOUND},
		'{CLOCK_RESET, 32'd1000, 1'b0, NONE_FOUND},
		// slow clock: every rate is zero
		'{32'd100, 32'd1, 1'b1, '{8'd2, 1'b0, 32'd0, 32'd1, 1'b1}},
		'{32'd100, 32'd0, 1'b1, NONE_FOUND},
		'{32'd256, 32'd5, 1'b1, '{8'd2, 1'b0, 32'd0, 32'd5, 1'b1}},
		'{32'hFFFF_FFFF, 32'd4194303, 1'b1, '{8'd2, 1'b0, 32'd4194303, 32'd0, 1'b1}},
		'{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, NONE_FOUND},
		'{32'hFFFF_FFFF, 32'h5555_5555, 1'b0, NONE_FOUND},
		'{32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, NONE_FOUND}
	};

	audio_clock_divider_search_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Sweep every divider/odd pair; keep the first strictly closest rate, stop on exact.
	function automatic search_result_t search_divider(input logic [HZ_W-1:0] ref_hz,
			input logic [HZ_W-1:0] target);
		logic [63:0]     bound;
		logic [HZ_W-1:0] denom;
		logic [HZ_W-1:0] rate;
		logic [HZ_W-1:0] err;
		search_result_t  best;
		bit              exact;
		bound = 64'(target) * 64'd100;
		best = NONE_FOUND;
		exact = 1'b0;
		for (int d = 2; d <= ACDS_MAX_DIVIDER && !exact; d++) begin
			for (int o = 0; o <= 1 && !exact; o++) begin
				denom = HZ_W'((2 * d + o) * 256);
				rate = ref_hz / denom;
				err = (rate > target) ? rate - target : target - rate;
				if (best.found ? (err < best.error_hz) : (64'(err) < bound)) begin
					best = '{divider: DIV_W'(d), odd_bit: o[0], real_hz: rate,
						error_hz: err, found: 1'b1};
					exact = (err == '0);
				end
			end
		end
		return best;
	endfunction

	task automatic note_mismatch(input string field, input logic [HZ_W-1:0] got,
			input logic [HZ_W-1:0] want);
		$display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
		bad_fields++;
	endtask

	task automatic offer_target(input logic [HZ_W-1:0] target, input bit typed,
			input search_result_t want);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= target;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		awaited_results.push_back(typed ? want : search_divider(clock_hz, target));
	endtask

	task automatic write_clock(input logic [HZ_W-1:0] value);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		clock_hz = value;
	endtask

	task automatic run_random(input int count, input int pause_at);
		logic [HZ_W-1:0] target;
		int              pick;
		int              div;
		int              odd;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) begin
				// hold the sender until the block has drained
				s_tvalid <= 1'b0;
				while (awaited_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(99, 0);
			if (pick < 10) begin
				target = $urandom();
			end else begin
				// mostly exact hits at small dividers, which end the sweep early
				div = ($urandom_range(19, 0) == 0) ? $urandom_range(255, 2)
					: $urandom_range(24, 2);
				odd = $urandom_range(1, 0);
				target = clock_hz / HZ_W'((2 * div + odd) * 256);
				if (pick < 16) target = target + HZ_W'($urandom_range(3, 1));
			end
			offer_target(target, 1'b0, NONE_FOUND);
		end
	endtask

	// Receiver: random ready, plus one long hold-off to back up the input side.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!held && results_seen == PLAN_ROWS + 10) begin
				m_tready <= 1'b0;
				hold_left = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with no request outstanding", $realtime);
				bad_fields++;
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata[7:0] != want.divider)
					note_mismatch("divider", HZ_W'(m_tdata[7:0]), HZ_W'(want.divider));
				if (m_tdata[8] != want.odd_bit)
					note_mismatch("odd_bit", HZ_W'(m_tdata[8]), HZ_W'(want.odd_bit));
				if (m_tdata[40:9] != want.real_hz)
					note_mismatch("real_hz", m_tdata[40:9], want.real_hz);
				if (m_tdata[72:41] != want.error_hz)
					note_mismatch("error_hz", m_tdata[72:41], want.error_hz);
				if (m_tuser != want.found)
					note_mismatch("found", HZ_W'(m_tuser), HZ_W'(want.found));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].clock_hz != clock_hz) write_clock(plan[i].clock_hz);
			offer_target(plan[i].target, plan[i].typed, plan[i].want);
		end

		write_clock(32'd12288000);
		run_random(34, -1);

		send_idle_pct = 87;
		recv_idle_pct = 16;
		write_clock($urandom_range(32'hFFFF_FFFF, 32'd1000000));
		run_random(34, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_clock(32'd11289600);
		run_random(34, 17);

		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (bad_fields == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/acds_pkg.sv
src/acds_sdiv.sv
src/acds_datapath.sv
src/acds_ctrl.sv
src/audio_clock_divider_search_top.sv
src/acds_checker.sv
verif/tb_audio_clock_divider_search_top.sv
